### design/nfc_response_frame_checker_defines.svh
// Assertion macros for the response frame checker.
// Used by the top level only; takes no other file.
`ifndef NFC_RESPONSE_FRAME_CHECKER_DEFINES_SVH
`define NFC_RESPONSE_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication, held off while reset is high.
`define NFC_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is high.
`define NFC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/nfcrfc_pkg.sv
// Types, constants and helpers for the response frame checker.
// No dependencies; imported by nfc_response_frame_checker.
package nfcrfc_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 64;
  localparam int unsigned FRAME_OVERHEAD   = 7;
  localparam int unsigned HEADER_BYTES     = 5;
  localparam int unsigned LEAST_FRAME      = 9;
  localparam int unsigned LEAST_LEN        = 2;
  localparam logic [7:0]  TFI_TO_HOST      = 8'hD5;

  localparam int unsigned POS_W = 9;
  localparam int unsigned CFG_W = 10;

  localparam logic [7:0]  EXP_CMD_RST  = 8'd0;
  localparam logic [8:0]  MIN_LEN_RST  = 9'd9;
  localparam logic [9:0]  CAPACITY_RST = 10'd64;

  typedef enum logic [1:0] {
    CFG_EXPECTED_COMMAND = 2'd0,
    CFG_MIN_FRAME_BYTES  = 2'd1,
    CFG_CAPACITY_BYTES   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PROTOCOL = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       frame_done;
    status_t    status;
    logic [7:0] data_len;
  } out_item_t;

  // preamble and start codes
  function automatic logic [7:0] lead_byte(input logic [1:0] pos);
    logic [7:0] v;
    case (pos)
      2'd0:    v = 8'h00;
      2'd1:    v = 8'h00;
      2'd2:    v = 8'hFF;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

### design/nfc_response_frame_checker.sv
// Response frame checker, top level: header, length, command, capacity and checksum checks.
// Depends on nfcrfc_pkg and nfc_response_frame_checker_defines.svh.
//
//  port group   | dir | handshake            | beat
//  -------------+-----+----------------------+------------------------------
//  in_*         | in  | in_valid / in_ready  | one received byte + start flag
//  out_*        | out | out_valid / out_ready| one result per input beat
//  cfg_*        | in  | cfg_wr_en            | one register write, no wait
//
// Every input beat gives exactly one result beat, in the next cycle.
// One beat per cycle sustained while out_ready is high: the running sum,
// position counter and the final checks sit in one pass between the state
// registers and the result register. in_ready drops only while a result
// waits and out_ready is low. rst is synchronous, active high: clears frame
// state, the result register's valid flag and loads register reset values.
`include "nfc_response_frame_checker_defines.svh"

module nfc_response_frame_checker
  import nfcrfc_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // largest frame the caller's buffer type can ever hold
  localparam logic [9:0] BufLimit = 10'(BUFFER_BYTES);

  // configuration registers
  logic [7:0] expected_command;
  logic [8:0] min_frame_bytes;
  logic [9:0] capacity_bytes;

  // frame state
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       length_byte, length_byte_next;
  logic [7:0]       data_sum, data_sum_next;
  logic             header_failed, header_failed_next;
  logic             body_failed, body_failed_next;
  logic             in_frame, in_frame_next;

  out_item_t        result_next;
  logic             accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_command <= EXP_CMD_RST;
      min_frame_bytes  <= MIN_LEN_RST;
      capacity_bytes   <= CAPACITY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_EXPECTED_COMMAND: expected_command <= cfg_data[7:0];
        CFG_MIN_FRAME_BYTES:  min_frame_bytes  <= cfg_data[8:0];
        CFG_CAPACITY_BYTES:   capacity_bytes   <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // one pass over the incoming byte
  always_comb begin
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] len9;
    logic [POS_W-1:0] flen;
    logic [7:0]       b;
    logic             hdr_f;
    logic             pay;
    logic             done;

    b    = in_data.rx_byte;
    pay  = 1'b0;
    done = 1'b0;

    byte_position_next = byte_position;
    length_byte_next   = length_byte;
    data_sum_next      = data_sum;
    header_failed_next = header_failed;
    body_failed_next   = body_failed;
    in_frame_next      = in_frame;
    result_next        = '0;

    // restart: the open frame, if any, is dropped silently
    if (in_data.frame_start) begin
      byte_position_next = '0;
      length_byte_next   = '0;
      data_sum_next      = '0;
      header_failed_next = 1'b0;
      body_failed_next   = 1'b0;
      in_frame_next      = 1'b1;
    end

    p     = byte_position_next;
    len9  = {1'b0, length_byte_next};
    flen  = len9 + POS_W'(FRAME_OVERHEAD);
    hdr_f = header_failed_next;

    if (in_frame_next) begin
      if (p < 9'd3) begin
        if (b != lead_byte(p[1:0])) header_failed_next = 1'b1;
      end else if (p == 9'd3) begin
        length_byte_next = b;
      end else if (p == POS_W'(HEADER_BYTES - 1)) begin
        if ((8'(length_byte_next + b) != 8'd0) || (len9 < POS_W'(LEAST_LEN))) begin
          header_failed_next = 1'b1;
        end
      end else begin
        if (p <= len9 + 9'd5) data_sum_next = data_sum_next + b;
        if (p == POS_W'(HEADER_BYTES) && b != TFI_TO_HOST) body_failed_next = 1'b1;
        if (p == POS_W'(HEADER_BYTES + 1) && b != 8'(expected_command + 8'd1)) begin
          body_failed_next = 1'b1;
        end
        pay = !hdr_f && (p >= 9'd7) && (p <= len9 + 9'd4);
        if (p == len9 + 9'd6) begin
          done = 1'b1;
          if (hdr_f) begin
            result_next.status = ST_PROTOCOL;
          end else if (({1'b0, flen} > capacity_bytes) || ({1'b0, flen} > BufLimit)) begin
            result_next.status = ST_OVERFLOW;
          end else if ((flen < min_frame_bytes) || (flen < POS_W'(LEAST_FRAME))) begin
            result_next.status = ST_PROTOCOL;
          end else if (body_failed_next || (data_sum_next != 8'd0) || (b != 8'd0)) begin
            // data_sum_next already folds in DCS at this position
            result_next.status = ST_PROTOCOL;
          end else begin
            result_next.data_len = 8'(length_byte_next - 8'(LEAST_LEN));
          end
        end
      end

      if (done) begin
        in_frame_next      = 1'b0;
        byte_position_next = '0;
      end else begin
        byte_position_next = p + 9'd1;
      end
    end

    result_next.payload_valid = pay;
    result_next.payload_byte  = pay ? b : 8'd0;
    result_next.frame_done    = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      length_byte   <= '0;
      data_sum      <= '0;
      header_failed <= 1'b0;
      body_failed   <= 1'b0;
      in_frame      <= 1'b0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      length_byte   <= length_byte_next;
      data_sum      <= data_sum_next;
      header_failed <= header_failed_next;
      body_failed   <= body_failed_next;
      in_frame      <= in_frame_next;
    end
  end

  // result register; payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_data <= result_next;
  end

  // payload and end of frame never share a beat
  `NFC_ASSERT_NOW(a_pay_not_done, clk, rst, out_valid && out_data.payload_valid, !out_data.frame_done, "payload beat flagged as frame end")

  // a stray byte outside a frame yields an all-zero result
  `NFC_ASSERT_NEXT(a_idle_zero, clk, rst, accept && !in_data.frame_start && !in_frame, out_valid && (out_data == '0), "stray byte produced a non-zero result")

  // position never runs past the frame's last byte
  `NFC_ASSERT_NOW(a_pos_bound, clk, rst, in_frame && (byte_position > 9'd4), byte_position <= ({1'b0, length_byte} + 9'd6), "byte position beyond frame end")

endmodule
